/* src/skwt_pkg.sv */
// shared constants, codes and key compare for the serial keyed window table
package skwt_pkg;

    // default table depth
    localparam int CAPACITY_DEF = 32;

    // field widths
    localparam int KEY_W     = 8;
    localparam int VAL_W     = 32;
    localparam int CMD_W     = 2;
    localparam int STAT_W    = 2;
    localparam int CNT_OUT_W = 6;

    // half of the key space, breakpoint of serial compare
    localparam logic [KEY_W-1:0] HALF_RANGE = 8'd128;

    // command codes
    localparam logic [CMD_W-1:0] CMD_PUSH  = 2'd0;
    localparam logic [CMD_W-1:0] CMD_ERASE = 2'd1;
    localparam logic [CMD_W-1:0] CMD_CLEAR = 2'd2;
    localparam logic [CMD_W-1:0] CMD_QUERY = 2'd3;

    // status codes
    localparam logic [STAT_W-1:0] STAT_OK      = 2'd0;
    localparam logic [STAT_W-1:0] STAT_FULL    = 2'd1;
    localparam logic [STAT_W-1:0] STAT_RESTART = 2'd2;

    // x precedes y in serial number order
    function automatic logic serial_before(input logic [KEY_W-1:0] x,
                                           input logic [KEY_W-1:0] y);
        logic [KEY_W-1:0] d;
        d = y - x;
        if (d == HALF_RANGE) begin
            return x < y;
        end
        return (x != y) && (d < HALF_RANGE);
    endfunction

endpackage

/* src/serial_keyed_window_table_core.sv */
// serial keyed window table: sorted key/value store with window ends and range query
//
//  channel | signals                                            | dir | handshake
//  --------+----------------------------------------------------+-----+-------------------
//  in      | i_command i_key i_key_hi i_value                   | in  | i_valid / o_ready
//  out     | o_out_key o_out_value o_has_entry o_last o_status  | out | o_valid / i_ready
//          | o_entry_count o_oldest_key o_newest_key            |     |
//
// one beat at a time, all work goes through one table memory port pair (registered read).
// push walks down from the top, moving each larger key up, before it writes; clear and a full
// push go straight to their status beat; erase streams every held entry; query reads every held
// entry, in two passes when the range wraps, and reads none when the range is empty. o_ready
// is high only in idle; a finished beat may wait in the output register while the next command
// is taken, a busy output stalls a query at each further match and every command at its closing
// beat. reset clears the state, counts, window ends and the valid and pending flags, not the table.
module serial_keyed_window_table_core #(
    parameter int CAPACITY = skwt_pkg::CAPACITY_DEF
) (
    input  logic                                  i_clk,
    input  logic                                  i_rst_n,
    // command channel
    input  logic                                  i_valid,
    output logic                                  o_ready,
    input  logic [skwt_pkg::CMD_W-1:0]            i_command,
    input  logic [skwt_pkg::KEY_W-1:0]            i_key,
    input  logic [skwt_pkg::KEY_W-1:0]            i_key_hi,
    input  logic signed [skwt_pkg::VAL_W-1:0]     i_value,
    // result channel
    output logic                                  o_valid,
    input  logic                                  i_ready,
    output logic [skwt_pkg::KEY_W-1:0]            o_out_key,
    output logic signed [skwt_pkg::VAL_W-1:0]     o_out_value,
    output logic                                  o_has_entry,
    output logic                                  o_last,
    output logic [skwt_pkg::STAT_W-1:0]           o_status,
    output logic [skwt_pkg::CNT_OUT_W-1:0]        o_entry_count,
    output logic [skwt_pkg::KEY_W-1:0]            o_oldest_key,
    output logic [skwt_pkg::KEY_W-1:0]            o_newest_key
);

    localparam int CW = $clog2(CAPACITY + 1);
    localparam int IW = (CAPACITY > 1) ? $clog2(CAPACITY) : 1;
    localparam int KW = skwt_pkg::KEY_W;
    localparam int VW = skwt_pkg::VAL_W;
    localparam int SW = skwt_pkg::STAT_W;

    typedef enum logic [3:0] {
        ST_IDLE,
        ST_PUSH_RD,
        ST_PUSH_CHK,
        ST_ERASE,
        ST_ERASE_FIN,
        ST_QRY_RD,
        ST_QRY_CHK,
        ST_QRY_END,
        ST_EMIT
    } t_state;

    // table memory
    logic [KW-1:0] mem_key [CAPACITY];
    logic [VW-1:0] mem_val [CAPACITY];
    logic          mem_we;
    logic [IW-1:0] mem_waddr;
    logic [KW-1:0] mem_wkey;
    logic [VW-1:0] mem_wval;
    logic          mem_re;
    logic [IW-1:0] mem_raddr;
    logic [KW-1:0] r_rd_key;
    logic [VW-1:0] r_rd_val;

    // sequencer state
    t_state        r_state, n_state;
    logic [CW-1:0] r_count, n_count;
    logic [KW-1:0] r_oldest, n_oldest;
    logic [KW-1:0] r_newest, n_newest;
    logic [KW-1:0] r_key, n_key;
    logic [KW-1:0] r_key_hi, n_key_hi;
    logic [VW-1:0] r_val, n_val;
    logic [SW-1:0] r_status, n_status;
    logic [CW-1:0] r_ptr, n_ptr;
    logic [CW-1:0] r_w, n_w;
    logic          r_dv, n_dv;
    logic [CW-1:0] r_nm, n_nm;
    logic [KW-1:0] r_after, n_after;
    logic          r_after_got, n_after_got;
    logic [KW-1:0] r_prev, n_prev;
    logic          r_prev_got, n_prev_got;
    logic [KW-1:0] r_first, n_first;
    logic [KW-1:0] r_lastk, n_lastk;
    logic          r_any, n_any;
    logic          r_wrap, n_wrap;
    logic          r_pass, n_pass;
    logic          r_pend, n_pend;
    logic [KW-1:0] r_pend_key, n_pend_key;
    logic [VW-1:0] r_pend_val, n_pend_val;

    // output register
    logic          r_o_valid, n_o_valid;
    logic [KW-1:0] r_o_key, n_o_key;
    logic [VW-1:0] r_o_value, n_o_value;
    logic          r_o_has, n_o_has;
    logic          r_o_last, n_o_last;
    logic [SW-1:0] r_o_status, n_o_status;
    logic [skwt_pkg::CNT_OUT_W-1:0] r_o_count, n_o_count;
    logic [KW-1:0] r_o_oldest, n_o_oldest;
    logic [KW-1:0] r_o_newest, n_o_newest;

    // output load request
    logic          ld_out;
    logic [KW-1:0] ld_key;
    logic [VW-1:0] ld_val;
    logic          ld_has;
    logic          ld_last;
    logic [SW-1:0] ld_status;

    logic          out_free;
    logic [CW-1:0] ptr_m1;
    logic          q_match;

    assign out_free = !r_o_valid || i_ready;
    assign ptr_m1   = r_ptr - CW'(1);

    // range match for the current query pass
    always_comb begin
        if (!r_wrap) begin
            q_match = (r_rd_key >= r_key) && (r_rd_key <= r_key_hi);
        end else if (!r_pass) begin
            q_match = (r_rd_key >= r_key);
        end else begin
            q_match = (r_rd_key <= r_key_hi);
        end
    end

    // table memory, registered read
    always_ff @(posedge i_clk) begin
        if (mem_we) begin
            mem_key[mem_waddr] <= mem_wkey;
            mem_val[mem_waddr] <= mem_wval;
        end
        if (mem_re) begin
            r_rd_key <= mem_key[mem_raddr];
            r_rd_val <= mem_val[mem_raddr];
        end
    end

    // sequencer next state
    always_comb begin
        n_state     = r_state;
        n_count     = r_count;
        n_oldest    = r_oldest;
        n_newest    = r_newest;
        n_key       = r_key;
        n_key_hi    = r_key_hi;
        n_val       = r_val;
        n_status    = r_status;
        n_ptr       = r_ptr;
        n_w         = r_w;
        n_dv        = r_dv;
        n_nm        = r_nm;
        n_after     = r_after;
        n_after_got = r_after_got;
        n_prev      = r_prev;
        n_prev_got  = r_prev_got;
        n_first     = r_first;
        n_lastk     = r_lastk;
        n_any       = r_any;
        n_wrap      = r_wrap;
        n_pass      = r_pass;
        n_pend      = r_pend;
        n_pend_key  = r_pend_key;
        n_pend_val  = r_pend_val;
        mem_we      = 1'b0;
        mem_waddr   = '0;
        mem_wkey    = '0;
        mem_wval    = '0;
        mem_re      = 1'b0;
        mem_raddr   = '0;
        ld_out      = 1'b0;
        ld_key      = '0;
        ld_val      = '0;
        ld_has      = 1'b0;
        ld_last     = 1'b1;
        ld_status   = skwt_pkg::STAT_OK;

        case (r_state)
            // take a command beat
            ST_IDLE: begin
                if (i_valid) begin
                    n_key    = i_key;
                    n_key_hi = i_key_hi;
                    n_val    = i_value;
                    n_status = skwt_pkg::STAT_OK;
                    case (i_command)
                        skwt_pkg::CMD_PUSH: begin
                            if (r_count == CW'(CAPACITY)) begin
                                n_status = skwt_pkg::STAT_FULL;
                                n_state  = ST_EMIT;
                            end else if (r_count == '0) begin
                                n_oldest = i_key;
                                n_newest = i_key;
                                n_ptr    = '0;
                                n_state  = ST_PUSH_RD;
                            end else if (skwt_pkg::serial_before(i_key, r_oldest) &&
                                         skwt_pkg::serial_before(r_newest, i_key)) begin
                                n_count  = '0;
                                n_oldest = i_key;
                                n_newest = i_key;
                                n_status = skwt_pkg::STAT_RESTART;
                                n_ptr    = '0;
                                n_state  = ST_PUSH_RD;
                            end else begin
                                if (skwt_pkg::serial_before(i_key, r_oldest)) begin
                                    n_oldest = i_key;
                                end
                                if (skwt_pkg::serial_before(r_newest, i_key)) begin
                                    n_newest = i_key;
                                end
                                n_ptr   = r_count;
                                n_state = ST_PUSH_RD;
                            end
                        end
                        skwt_pkg::CMD_ERASE: begin
                            n_ptr       = '0;
                            n_w         = '0;
                            n_dv        = 1'b0;
                            n_nm        = '0;
                            n_after_got = 1'b0;
                            n_prev_got  = 1'b0;
                            n_any       = 1'b0;
                            n_state     = ST_ERASE;
                        end
                        skwt_pkg::CMD_CLEAR: begin
                            n_count  = '0;
                            n_oldest = '0;
                            n_newest = '0;
                            n_state  = ST_EMIT;
                        end
                        default: begin
                            n_pend = 1'b0;
                            n_ptr  = '0;
                            n_pass = 1'b0;
                            n_wrap = (i_key_hi < i_key);
                            if (skwt_pkg::serial_before(i_key_hi, i_key)) begin
                                n_state = ST_QRY_END;
                            end else begin
                                n_state = ST_QRY_RD;
                            end
                        end
                    endcase
                end
            end

            // insert: walk down from the top, shifting larger keys up
            ST_PUSH_RD: begin
                if (r_ptr == '0) begin
                    mem_we    = 1'b1;
                    mem_waddr = '0;
                    mem_wkey  = r_key;
                    mem_wval  = r_val;
                    n_count   = r_count + CW'(1);
                    n_state   = ST_EMIT;
                end else begin
                    mem_re    = 1'b1;
                    mem_raddr = ptr_m1[IW-1:0];
                    n_state   = ST_PUSH_CHK;
                end
            end

            ST_PUSH_CHK: begin
                mem_we    = 1'b1;
                mem_waddr = r_ptr[IW-1:0];
                if (r_rd_key > r_key) begin
                    mem_wkey = r_rd_key;
                    mem_wval = r_rd_val;
                    n_ptr    = ptr_m1;
                    n_state  = ST_PUSH_RD;
                end else begin
                    mem_wkey = r_key;
                    mem_wval = r_val;
                    n_count  = r_count + CW'(1);
                    n_state  = ST_EMIT;
                end
            end

            // erase: stream the table, compacting survivors and noting neighbors
            ST_ERASE: begin
                if (r_ptr < r_count) begin
                    mem_re    = 1'b1;
                    mem_raddr = r_ptr[IW-1:0];
                    n_ptr     = r_ptr + CW'(1);
                    n_dv      = 1'b1;
                end else begin
                    n_dv = 1'b0;
                end
                if (r_dv) begin
                    n_any   = 1'b1;
                    n_lastk = r_rd_key;
                    if (!r_any) begin
                        n_first = r_rd_key;
                    end
                    if (r_rd_key == r_key) begin
                        if (r_nm == '0) begin
                            n_prev_got = r_any;
                            n_prev     = r_lastk;
                        end
                        n_nm = r_nm + CW'(1);
                    end else begin
                        mem_we    = 1'b1;
                        mem_waddr = r_w[IW-1:0];
                        mem_wkey  = r_rd_key;
                        mem_wval  = r_rd_val;
                        n_w       = r_w + CW'(1);
                        if ((r_nm != '0) && !r_after_got) begin
                            n_after_got = 1'b1;
                            n_after     = r_rd_key;
                        end
                    end
                end
                if ((r_ptr == r_count) && !r_dv) begin
                    n_state = ST_ERASE_FIN;
                end
            end

            // erase: move window ends and drop the removed count
            ST_ERASE_FIN: begin
                if ((r_nm != '0) && (r_nm != r_count) && (r_oldest != r_newest)) begin
                    if (r_key == r_oldest) begin
                        n_oldest = r_after_got ? r_after : r_first;
                    end else if (r_key == r_newest) begin
                        n_newest = r_prev_got ? r_prev : r_lastk;
                    end
                end
                n_count = r_count - r_nm;
                n_state = ST_EMIT;
            end

            // query: read the next entry or move to the next pass
            ST_QRY_RD: begin
                if (r_ptr == r_count) begin
                    if (r_wrap && !r_pass) begin
                        n_pass = 1'b1;
                        n_ptr  = '0;
                    end else begin
                        n_state = ST_QRY_END;
                    end
                end else begin
                    mem_re    = 1'b1;
                    mem_raddr = r_ptr[IW-1:0];
                    n_state   = ST_QRY_CHK;
                end
            end

            // query: hold one match back so the final beat can carry last
            ST_QRY_CHK: begin
                if (q_match && r_pend) begin
                    if (out_free) begin
                        ld_out     = 1'b1;
                        ld_key     = r_pend_key;
                        ld_val     = r_pend_val;
                        ld_has     = 1'b1;
                        ld_last    = 1'b0;
                        n_pend_key = r_rd_key;
                        n_pend_val = r_rd_val;
                        n_ptr      = r_ptr + CW'(1);
                        n_state    = ST_QRY_RD;
                    end
                end else begin
                    if (q_match) begin
                        n_pend     = 1'b1;
                        n_pend_key = r_rd_key;
                        n_pend_val = r_rd_val;
                    end
                    n_ptr   = r_ptr + CW'(1);
                    n_state = ST_QRY_RD;
                end
            end

            // query: closing beat, empty when nothing matched
            ST_QRY_END: begin
                if (out_free) begin
                    ld_out  = 1'b1;
                    ld_has  = r_pend;
                    ld_key  = r_pend ? r_pend_key : '0;
                    ld_val  = r_pend ? r_pend_val : '0;
                    n_pend  = 1'b0;
                    n_state = ST_IDLE;
                end
            end

            // single status beat for push, erase and clear
            ST_EMIT: begin
                if (out_free) begin
                    ld_out    = 1'b1;
                    ld_status = r_status;
                    n_state   = ST_IDLE;
                end
            end

            default: begin
                n_state = ST_IDLE;
            end
        endcase
    end

    // output register next values
    always_comb begin
        n_o_valid  = r_o_valid && !i_ready;
        n_o_key    = r_o_key;
        n_o_value  = r_o_value;
        n_o_has    = r_o_has;
        n_o_last   = r_o_last;
        n_o_status = r_o_status;
        n_o_count  = r_o_count;
        n_o_oldest = r_o_oldest;
        n_o_newest = r_o_newest;
        if (ld_out) begin
            n_o_valid  = 1'b1;
            n_o_key    = ld_key;
            n_o_value  = ld_val;
            n_o_has    = ld_has;
            n_o_last   = ld_last;
            n_o_status = ld_status;
            n_o_count  = skwt_pkg::CNT_OUT_W'(r_count);
            n_o_oldest = r_oldest;
            n_o_newest = r_newest;
        end
    end

    // state and registered outputs
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state   <= ST_IDLE;
            r_count   <= '0;
            r_oldest  <= '0;
            r_newest  <= '0;
            r_dv      <= 1'b0;
            r_pend    <= 1'b0;
            r_o_valid <= 1'b0;
        end else begin
            r_state   <= n_state;
            r_count   <= n_count;
            r_oldest  <= n_oldest;
            r_newest  <= n_newest;
            r_dv      <= n_dv;
            r_pend    <= n_pend;
            r_o_valid <= n_o_valid;
        end
        r_key       <= n_key;
        r_key_hi    <= n_key_hi;
        r_val       <= n_val;
        r_status    <= n_status;
        r_ptr       <= n_ptr;
        r_w         <= n_w;
        r_nm        <= n_nm;
        r_after     <= n_after;
        r_after_got <= n_after_got;
        r_prev      <= n_prev;
        r_prev_got  <= n_prev_got;
        r_first     <= n_first;
        r_lastk     <= n_lastk;
        r_any       <= n_any;
        r_wrap      <= n_wrap;
        r_pass      <= n_pass;
        r_pend_key  <= n_pend_key;
        r_pend_val  <= n_pend_val;
        r_o_key     <= n_o_key;
        r_o_value   <= n_o_value;
        r_o_has     <= n_o_has;
        r_o_last    <= n_o_last;
        r_o_status  <= n_o_status;
        r_o_count   <= n_o_count;
        r_o_oldest  <= n_o_oldest;
        r_o_newest  <= n_o_newest;
    end

    // ports
    assign o_ready       = (r_state == ST_IDLE);
    assign o_valid       = r_o_valid;
    assign o_out_key     = r_o_key;
    assign o_out_value   = r_o_value;
    assign o_has_entry   = r_o_has;
    assign o_last        = r_o_last;
    assign o_status      = r_o_status;
    assign o_entry_count = r_o_count;
    assign o_oldest_key  = r_o_oldest;
    assign o_newest_key  = r_o_newest;

    // held count never passes the table depth
    a_count_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_count <= CW'(CAPACITY))
        else $error("held count above capacity");

    // every accepted command leaves idle
    a_accept_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_valid && o_ready) |=> (r_state != ST_IDLE))
        else $error("accepted command did not start work");

    // an empty beat always closes its command
    a_empty_last: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_o_valid && !r_o_has) |-> r_o_last)
        else $error("empty result beat without last");

    // compaction write pointer never passes the read pointer
    a_erase_order: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == ST_ERASE) |-> (r_w <= r_ptr))
        else $error("erase write pointer passed read pointer");

    // table writes stay inside the held region plus one
    a_write_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        mem_we |-> (CW'(mem_waddr) <= r_count))
        else $error("table write beyond held entries");

endmodule
